// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/sgma_pkg.sv =====
// ----------------------------------------------------------------------------
// sgma_pkg
// Types and codes of the stencil gather / multiply-accumulate core.
// ----------------------------------------------------------------------------
`default_nettype none

package sgma_pkg;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_STEP  = 2'd2;

    localparam logic [1:0] MODE_FLUX    = 2'd0;
    localparam logic [1:0] MODE_RESTORE = 2'd1;
    localparam logic [1:0] MODE_SAVE    = 2'd2;

    localparam logic [1:0] FIELD_LAST = 2'd2;

    localparam logic CFG_COMPONENT = 1'b0;
    localparam logic CFG_MODE      = 1'b1;

    localparam logic VK_READ = 1'b0;
    localparam logic VK_SAVE = 1'b1;

    localparam logic [63:0] DEF_NAN  = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] QNAN_BIT = 64'h0008_0000_0000_0000;
    localparam logic [10:0] EXP_MAX  = 11'h7FF;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [1:0]  field_sel;
        logic [11:0] cell_index;
        logic [11:0] point_index;
        logic [63:0] coeff;
        logic [63:0] data_value;
        logic        has_term;
        logic        last_term;
    } t_in_item;

    typedef struct packed {
        logic [63:0] value;
        logic        value_kind;
        logic [11:0] cell_out;
    } t_out_item;

    typedef enum logic {
        FP_OP_MUL,
        FP_OP_ADD
    } t_fpu_op;

    typedef struct packed {
        logic        start;
        t_fpu_op     op;
        logic [63:0] a;
        logic [63:0] b;
    } t_fpu_req;

    typedef struct packed {
        logic        ready;
        logic        done;
        logic [63:0] result;
    } t_fpu_rsp;

    typedef enum logic [2:0] {
        FP_IDLE,
        FP_MUL,
        FP_ALIGN,
        FP_NORM,
        FP_ROUND
    } t_fpu_state;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_DISPATCH,
        SQ_LOAD,
        SQ_MUL,
        SQ_ACC,
        SQ_FIN
    } t_seq_state;

endpackage

`default_nettype wire

// ===== design/sgma_mem.sv =====
// ----------------------------------------------------------------------------
// sgma_mem
// Single-port field store, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sgma_mem #(
    parameter int DEPTH = 12288,
    parameter int AW    = 14
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [63:0]   i_wdata,
    output logic      [63:0]   o_rdata
);

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/sgma_fpu.sv =====
// ----------------------------------------------------------------------------
// sgma_fpu
// Shared iterative double multiply / add unit, round to nearest even.
// ----------------------------------------------------------------------------
`default_nettype none

module sgma_fpu (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sgma_pkg::t_fpu_req i_req,
    output sgma_pkg::t_fpu_rsp     o_rsp
);

    sgma_pkg::t_fpu_state r_state, n_state;
    sgma_pkg::t_fpu_op    r_op, n_op;
    logic [63:0]         r_a, n_a, r_b, n_b;
    logic [1:0]          r_k, n_k;
    logic [111:0]        r_prod, n_prod;
    logic [106:0]        r_r, n_r;
    logic                r_sticky, n_sticky;
    logic signed [13:0]  r_e, n_e;
    logic                r_sign, n_sign, r_zsign, n_zsign;
    logic [63:0]         r_result, n_result;
    logic                r_done, n_done;

    function automatic logic [10:0] exp_of(input logic [63:0] x);
        return (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
    endfunction

    function automatic logic [52:0] man_of(input logic [63:0] x);
        return {(x[62:52] != 11'd0), x[51:0]};
    endfunction

    function automatic logic [107:0] shr_sticky(input logic [106:0] v, input logic [6:0] amt);
        logic [106:0] mask;
        mask = ~({107{1'b1}} << amt);
        return {v >> amt, |(v & mask)};
    endfunction

    // operand decode at start
    logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sa, sb;
    assign a_nan  = (i_req.a[62:52] == sgma_pkg::EXP_MAX) && (i_req.a[51:0] != 52'd0);
    assign b_nan  = (i_req.b[62:52] == sgma_pkg::EXP_MAX) && (i_req.b[51:0] != 52'd0);
    assign a_inf  = (i_req.a[62:52] == sgma_pkg::EXP_MAX) && (i_req.a[51:0] == 52'd0);
    assign b_inf  = (i_req.b[62:52] == sgma_pkg::EXP_MAX) && (i_req.b[51:0] == 52'd0);
    assign a_zero = (i_req.a[62:0] == 63'd0);
    assign b_zero = (i_req.b[62:0] == 63'd0);
    assign sa     = i_req.a[63];
    assign sb     = i_req.b[63];

    // partial product step
    logic [55:0]  mb_pad;
    logic [13:0]  chunk;
    logic [66:0]  partial;
    logic [111:0] part_sh, prod_sum;
    assign mb_pad   = {3'b000, man_of(r_b)};
    assign chunk    = mb_pad[14*r_k +: 14];
    assign partial  = man_of(r_a) * chunk;
    assign part_sh  = 112'(partial) << (7'd14 * 7'(r_k));
    assign prod_sum = r_prod + part_sh;

    // alignment and add
    logic [10:0]  ex, ey, d;
    logic [6:0]   al_amt;
    logic [106:0] rx, ry, ysh, yj, sum;
    logic         yst;
    assign ex     = exp_of(r_a);
    assign ey     = exp_of(r_b);
    assign d      = ex - ey;
    assign al_amt = (d > 11'd127) ? 7'd127 : d[6:0];
    assign rx     = {1'b0, man_of(r_a), 53'd0};
    assign ry     = {1'b0, man_of(r_b), 53'd0};
    assign {ysh, yst} = shr_sticky(ry, al_amt);
    assign yj     = ysh | {106'd0, yst};
    assign sum    = (r_a[63] == r_b[63]) ? (rx + yj) : (rx - yj);

    // denormalising shift
    logic signed [13:0] rs_full;
    logic [6:0]         rs_amt;
    logic [106:0]       rs_val;
    logic               rs_st;
    assign rs_full = 14'sd1 - r_e;
    assign rs_amt  = (rs_full > 14'sd127) ? 7'd127 : rs_full[6:0];
    assign {rs_val, rs_st} = shr_sticky(r_r, rs_amt);

    // rounding
    logic [52:0]        mant, m_fin;
    logic               g, st, up;
    logic [53:0]        m54;
    logic signed [13:0] e_fin;
    logic [63:0]        rnd_result;
    always_comb begin
        mant = r_r[105:53];
        g    = r_r[52];
        st   = (|r_r[51:0]) | r_sticky;
        up   = g & (st | mant[0]);
        m54  = {1'b0, mant} + 54'(up);
        if (m54[53]) begin
            m_fin = m54[53:1];
            e_fin = r_e + 14'sd1;
        end else begin
            m_fin = m54[52:0];
            e_fin = r_e;
        end
        if (e_fin >= 14'sd2047) begin
            rnd_result = {r_sign, sgma_pkg::EXP_MAX, 52'd0};
        end else begin
            rnd_result = {r_sign, (m_fin[52] ? e_fin[10:0] : 11'd0), m_fin[51:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sgma_pkg::FP_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_a      <= n_a;
        r_b      <= n_b;
        r_k      <= n_k;
        r_prod   <= n_prod;
        r_r      <= n_r;
        r_sticky <= n_sticky;
        r_e      <= n_e;
        r_sign   <= n_sign;
        r_zsign  <= n_zsign;
        r_result <= n_result;
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_a      = r_a;
        n_b      = r_b;
        n_k      = r_k;
        n_prod   = r_prod;
        n_r      = r_r;
        n_sticky = r_sticky;
        n_e      = r_e;
        n_sign   = r_sign;
        n_zsign  = r_zsign;
        n_result = r_result;
        n_done   = 1'b0;
        case (r_state)
            sgma_pkg::FP_IDLE: begin
                if (i_req.start) begin
                    n_op = i_req.op;
                    if (a_nan) begin
                        n_result = i_req.a | sgma_pkg::QNAN_BIT;
                        n_done   = 1'b1;
                    end else if (b_nan) begin
                        n_result = i_req.b | sgma_pkg::QNAN_BIT;
                        n_done   = 1'b1;
                    end else if (i_req.op == sgma_pkg::FP_OP_MUL) begin
                        if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                            n_result = sgma_pkg::DEF_NAN;
                            n_done   = 1'b1;
                        end else if (a_inf || b_inf) begin
                            n_result = {sa ^ sb, sgma_pkg::EXP_MAX, 52'd0};
                            n_done   = 1'b1;
                        end else begin
                            n_a      = i_req.a;
                            n_b      = i_req.b;
                            n_prod   = '0;
                            n_k      = 2'd0;
                            n_e      = 14'(exp_of(i_req.a)) + 14'(exp_of(i_req.b)) - 14'd1022;
                            n_sign   = sa ^ sb;
                            n_zsign  = sa ^ sb;
                            n_sticky = 1'b0;
                            n_state  = sgma_pkg::FP_MUL;
                        end
                    end else begin
                        if (a_inf && b_inf && (sa != sb)) begin
                            n_result = sgma_pkg::DEF_NAN;
                            n_done   = 1'b1;
                        end else if (a_inf) begin
                            n_result = i_req.a;
                            n_done   = 1'b1;
                        end else if (b_inf) begin
                            n_result = i_req.b;
                            n_done   = 1'b1;
                        end else begin
                            if (i_req.a[62:0] >= i_req.b[62:0]) begin
                                n_a = i_req.a;
                                n_b = i_req.b;
                            end else begin
                                n_a = i_req.b;
                                n_b = i_req.a;
                            end
                            n_zsign  = sa & sb;
                            n_sticky = 1'b0;
                            n_state  = sgma_pkg::FP_ALIGN;
                        end
                    end
                end
            end
            sgma_pkg::FP_MUL: begin
                n_prod = prod_sum;
                n_k    = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_r     = prod_sum[106:0];
                    n_state = sgma_pkg::FP_NORM;
                end
            end
            sgma_pkg::FP_ALIGN: begin
                n_r     = sum;
                n_e     = 14'(ex);
                n_sign  = r_a[63];
                n_state = sgma_pkg::FP_NORM;
            end
            sgma_pkg::FP_NORM: begin
                if ((r_r == 107'd0) && !r_sticky) begin
                    n_result = {r_zsign, 63'd0};
                    n_done   = 1'b1;
                    n_state  = sgma_pkg::FP_IDLE;
                end else if (r_r[106]) begin
                    n_r      = r_r >> 1;
                    n_sticky = r_sticky | r_r[0];
                    n_e      = r_e + 14'sd1;
                end else if (!r_r[105] && (r_e > 14'sd1)) begin
                    if ((r_r[105:98] == 8'd0) && (r_e > 14'sd8)) begin
                        n_r = r_r << 8;
                        n_e = r_e - 14'sd8;
                    end else begin
                        n_r = r_r << 1;
                        n_e = r_e - 14'sd1;
                    end
                end else if (r_e < 14'sd1) begin
                    n_r      = rs_val;
                    n_sticky = r_sticky | rs_st;
                    n_e      = 14'sd1;
                end else begin
                    n_state = sgma_pkg::FP_ROUND;
                end
            end
            sgma_pkg::FP_ROUND: begin
                n_result = rnd_result;
                n_done   = 1'b1;
                n_state  = sgma_pkg::FP_IDLE;
            end
            default: begin
                n_state = sgma_pkg::FP_IDLE;
            end
        endcase
    end

    assign o_rsp.ready  = (r_state == sgma_pkg::FP_IDLE);
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_result;

endmodule

`default_nettype wire

// ===== design/stencil_gather_mac_apply_core.sv =====
// ----------------------------------------------------------------------------
// stencil_gather_mac_apply_core
// Three double-precision velocity field stores with host access and a
// stencil multiply-accumulate, restore and save applied to the selected component.
//
//   channel  direction  handshake               payload
//   in       input      i_in_valid/o_in_stall    i_in_data  (t_in_item)
//   out      output     o_out_valid/i_out_stall  o_out_data (t_out_item)
//   cfg      input      i_cfg_we                 i_cfg_index, i_cfg_data
//
// Field write: request captured, then stored. Field read or save: request captured,
// store read issued, then the result registered when the output is not stalled.
// Flux term: store read and dispatch, then the shared FP unit runs a multiply
// (partial-product steps) and an add (an align step), each followed by normalise
// steps and a round step. Closing flux step adds one more FP add.
// Synchronous active-low reset; the field store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module stencil_gather_mac_apply_core #(
    parameter int FIELD_DEPTH = 4096
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire sgma_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output sgma_pkg::t_out_item      o_out_data,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_index,
    input  wire logic [1:0]          i_cfg_data
);

    localparam int MEM_DEPTH = 3 * FIELD_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);

    sgma_pkg::t_seq_state r_state, n_state;
    sgma_pkg::t_in_item   r_item;
    sgma_pkg::t_out_item  r_out, n_out;
    logic                r_out_valid, n_out_valid;
    logic [63:0]         r_acc, n_acc;
    logic                r_rd_ok, n_rd_ok;
    logic [1:0]          r_component, r_mode;

    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_addr;
    logic [63:0]         mem_wdata, mem_rdata, rdata;
    sgma_pkg::t_fpu_req   fpu_req;
    sgma_pkg::t_fpu_rsp   fpu_rsp;
    logic                fpu_wait;

    function automatic logic cell_ok(input logic [1:0] sel, input logic [11:0] idx);
        return (sel <= sgma_pkg::FIELD_LAST) && (32'(idx) < FIELD_DEPTH);
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [1:0] sel,
                                                input logic [11:0] idx);
        return AW'(sel) * AW'(FIELD_DEPTH) + AW'(idx);
    endfunction

    sgma_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    sgma_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fpu_req),
        .o_rsp   (fpu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_component <= 2'd0;
            r_mode      <= 2'd0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == sgma_pkg::CFG_COMPONENT) begin
                r_component <= i_cfg_data;
            end else begin
                r_mode <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sgma_pkg::SQ_IDLE;
            r_out_valid <= 1'b0;
            r_acc       <= 64'd0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_acc       <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == sgma_pkg::SQ_IDLE) && i_in_valid) begin
            r_item <= i_in_data;
        end
        r_out   <= n_out;
        r_rd_ok <= n_rd_ok;
    end

    assign rdata = r_rd_ok ? mem_rdata : 64'd0;

    always_comb begin
        n_state     = r_state;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        n_acc       = r_acc;
        n_rd_ok     = r_rd_ok;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = cell_addr(r_component, r_item.cell_index);
        mem_wdata   = r_item.data_value;
        fpu_req     = '0;
        case (r_state)
            sgma_pkg::SQ_IDLE: begin
                if (i_in_valid) begin
                    n_state = sgma_pkg::SQ_DISPATCH;
                end
            end
            sgma_pkg::SQ_DISPATCH: begin
                n_state = sgma_pkg::SQ_IDLE;
                case (r_item.req_type)
                    sgma_pkg::REQ_WRITE: begin
                        mem_addr = cell_addr(r_item.field_sel, r_item.cell_index);
                        mem_we   = cell_ok(r_item.field_sel, r_item.cell_index);
                    end
                    sgma_pkg::REQ_READ: begin
                        mem_addr = cell_addr(r_item.field_sel, r_item.cell_index);
                        n_rd_ok  = cell_ok(r_item.field_sel, r_item.cell_index);
                        mem_re   = n_rd_ok;
                        n_state  = sgma_pkg::SQ_LOAD;
                    end
                    sgma_pkg::REQ_STEP: begin
                        case (r_mode)
                            sgma_pkg::MODE_FLUX: begin
                                if (r_item.has_term) begin
                                    mem_addr = cell_addr(r_component, r_item.point_index);
                                    n_rd_ok  = cell_ok(r_component, r_item.point_index);
                                    mem_re   = n_rd_ok;
                                    n_state  = sgma_pkg::SQ_LOAD;
                                end else if (r_item.last_term) begin
                                    fpu_req.start = 1'b1;
                                    fpu_req.op    = sgma_pkg::FP_OP_ADD;
                                    fpu_req.a     = r_acc;
                                    fpu_req.b     = r_item.data_value;
                                    n_state       = sgma_pkg::SQ_FIN;
                                end
                            end
                            sgma_pkg::MODE_RESTORE: begin
                                if (r_item.last_term) begin
                                    mem_we = cell_ok(r_component, r_item.cell_index);
                                    n_acc  = 64'd0;
                                end
                            end
                            sgma_pkg::MODE_SAVE: begin
                                if (r_item.last_term) begin
                                    n_acc   = 64'd0;
                                    n_rd_ok = cell_ok(r_component, r_item.cell_index);
                                    mem_re  = n_rd_ok;
                                    n_state = sgma_pkg::SQ_LOAD;
                                end
                            end
                            default: begin
                                n_state = sgma_pkg::SQ_IDLE;
                            end
                        endcase
                    end
                    default: begin
                        n_state = sgma_pkg::SQ_IDLE;
                    end
                endcase
            end
            sgma_pkg::SQ_LOAD: begin
                if ((r_item.req_type == sgma_pkg::REQ_STEP) &&
                    (r_mode == sgma_pkg::MODE_FLUX)) begin
                    fpu_req.start = 1'b1;
                    fpu_req.op    = sgma_pkg::FP_OP_MUL;
                    fpu_req.a     = rdata;
                    fpu_req.b     = r_item.coeff;
                    n_state       = sgma_pkg::SQ_MUL;
                end else if (!r_out_valid || !i_out_stall) begin
                    n_out.value      = rdata;
                    n_out.value_kind = (r_item.req_type == sgma_pkg::REQ_READ) ?
                                       sgma_pkg::VK_READ : sgma_pkg::VK_SAVE;
                    n_out.cell_out   = r_item.cell_index;
                    n_out_valid      = 1'b1;
                    n_state          = sgma_pkg::SQ_IDLE;
                end
            end
            sgma_pkg::SQ_MUL: begin
                if (fpu_rsp.done) begin
                    fpu_req.start = 1'b1;
                    fpu_req.op    = sgma_pkg::FP_OP_ADD;
                    fpu_req.a     = r_acc;
                    fpu_req.b     = fpu_rsp.result;
                    n_state       = sgma_pkg::SQ_ACC;
                end
            end
            sgma_pkg::SQ_ACC: begin
                if (fpu_rsp.done) begin
                    n_acc = fpu_rsp.result;
                    if (r_item.last_term) begin
                        fpu_req.start = 1'b1;
                        fpu_req.op    = sgma_pkg::FP_OP_ADD;
                        fpu_req.a     = fpu_rsp.result;
                        fpu_req.b     = r_item.data_value;
                        n_state       = sgma_pkg::SQ_FIN;
                    end else begin
                        n_state = sgma_pkg::SQ_IDLE;
                    end
                end
            end
            sgma_pkg::SQ_FIN: begin
                if (fpu_rsp.done) begin
                    mem_wdata = fpu_rsp.result;
                    mem_we    = cell_ok(r_component, r_item.cell_index);
                    n_acc     = 64'd0;
                    n_state   = sgma_pkg::SQ_IDLE;
                end
            end
            default: begin
                n_state = sgma_pkg::SQ_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != sgma_pkg::SQ_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign fpu_wait = (r_state == sgma_pkg::SQ_MUL) || (r_state == sgma_pkg::SQ_ACC) ||
                      (r_state == sgma_pkg::SQ_FIN);

    `ASSERT_IMPLIES(a_fpu_start_idle, i_clk, i_rst_n, fpu_req.start, fpu_rsp.ready)
    `ASSERT_ALWAYS(a_mem_one_access, i_clk, i_rst_n, !(mem_we && mem_re))
    `ASSERT_IMPLIES(a_fpu_done_awaited, i_clk, i_rst_n, fpu_rsp.done, fpu_wait)

endmodule

`default_nettype wire

// ===== bench/stencil_gather_mac_apply_core_test.sv =====
// ----------------------------------------------------------------------------
// stencil_gather_mac_apply_core_test
// Self-checking bench: host writes, reads and stencil runs in every mode and
// component are driven with random gaps and stalls. A scoreboard predicts
// field contents, the double accumulator and every read or saved value.
// ----------------------------------------------------------------------------
`default_nettype none

module stencil_gather_mac_apply_core_test;

    localparam logic [1:0] REQ_BAD   = 2'd3;
    localparam logic [1:0] MODE_BAD  = 2'd3;
    localparam logic [1:0] FIELD_BAD = 2'd3;
    localparam int         RANDOM_REQUESTS = 1550;
    localparam int         IDLE_LIMIT = 5000;
    localparam int         SETTLE = 100;

    class field_scoreboard;
        bit [63:0]  cells [3][4096];
        real        acc;
        logic [1:0] comp;
        logic [1:0] mode;
        sgma_pkg::t_out_item pending [$];
        int         fails;

        function new();
            acc = 0.0;
            comp = 2'd0;
            mode = sgma_pkg::MODE_FLUX;
            fails = 0;
        endfunction

        function bit [63:0] fetch(logic [1:0] sel, logic [11:0] idx);
            return (sel > sgma_pkg::FIELD_LAST) ? 64'd0 : cells[sel][idx];
        endfunction

        function void put(logic [1:0] sel, logic [11:0] idx, bit [63:0] v);
            if (sel <= sgma_pkg::FIELD_LAST)
                cells[sel][idx] = v;
        endfunction

        function void set_reg(logic idx, logic [1:0] v);
            if (idx == sgma_pkg::CFG_COMPONENT)
                comp = v;
            else
                mode = v;
        endfunction

        function void note(sgma_pkg::t_in_item it);
            sgma_pkg::t_out_item r;
            real prod;
            case (it.req_type)
                sgma_pkg::REQ_WRITE: put(it.field_sel, it.cell_index, it.data_value);
                sgma_pkg::REQ_READ: begin
                    r.value = fetch(it.field_sel, it.cell_index);
                    r.value_kind = sgma_pkg::VK_READ;
                    r.cell_out = it.cell_index;
                    pending.push_back(r);
                end
                sgma_pkg::REQ_STEP: begin
                    if (mode == sgma_pkg::MODE_FLUX) begin
                        if (it.has_term) begin
                            prod = $bitstoreal(fetch(comp, it.point_index))
                                   * $bitstoreal(it.coeff);
                            acc = acc + prod;
                        end
                        if (it.last_term) begin
                            put(comp, it.cell_index,
                                $realtobits(acc + $bitstoreal(it.data_value)));
                            acc = 0.0;
                        end
                    end else if (mode != MODE_BAD && it.last_term) begin
                        acc = 0.0;
                        if (mode == sgma_pkg::MODE_RESTORE) begin
                            put(comp, it.cell_index, it.data_value);
                        end else begin
                            r.value = fetch(comp, it.cell_index);
                            r.value_kind = sgma_pkg::VK_SAVE;
                            r.cell_out = it.cell_index;
                            pending.push_back(r);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function bit is_nan(bit [63:0] b);
            return b[62:52] == sgma_pkg::EXP_MAX && b[51:0] != 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            fails++;
        endtask

        task check(sgma_pkg::t_out_item got);
            sgma_pkg::t_out_item e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result cell %0d", got.cell_out));
            end else begin
                e = pending.pop_front();
                if (got.value !== e.value && !(is_nan(e.value) && is_nan(got.value)))
                    report($sformatf("value %h, wanted %h (cell %0d)",
                                     got.value, e.value, e.cell_out));
                if (got.value_kind !== e.value_kind)
                    report($sformatf("kind %b, wanted %b", got.value_kind,
                                     e.value_kind));
                if (got.cell_out !== e.cell_out)
                    report($sformatf("cell %0d, wanted %0d", got.cell_out,
                                     e.cell_out));
            end
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    sgma_pkg::t_in_item  i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    sgma_pkg::t_out_item o_out_data;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_index = sgma_pkg::CFG_COMPONENT;
    logic [1:0] i_cfg_data = 2'd0;

    field_scoreboard sb = new();
    bit   written [4][4096];
    bit   no_gaps = 1'b0;
    bit   hold_req = 1'b0;
    int   idle_cycles = 0;
    int   sent = 0;

    stencil_gather_mac_apply_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[stencil_gather_mac_apply_core] ERROR");
            $finish;
        end
    end

    // result side
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                n = no_gaps ? 0 : $urandom_range(0, 3);
                if (n > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check(o_out_data);
        end
    end

    function logic [11:0] pool_index();
        return 12'($urandom_range(0, 63)) | ($urandom_range(0, 1) ? 12'hFC0 : 12'h000);
    endfunction

    // a cell that holds a value, unless the selector addresses nothing
    function logic [11:0] live_cell(logic [1:0] sel);
        logic [11:0] idx;
        idx = 12'($urandom);
        if (sel <= sgma_pkg::FIELD_LAST && !written[sel][idx])
            idx = pool_index();
        return idx;
    endfunction

    function logic [63:0] rand_double();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return {$urandom, $urandom};
        if (k == 1)
            return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 63'd0};
        return {1'($urandom), 11'($urandom_range(1003, 1043)), 20'($urandom), 32'($urandom)};
    endfunction

    task send(sgma_pkg::t_in_item it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note(it);
        if (it.req_type == sgma_pkg::REQ_WRITE && it.field_sel <= sgma_pkg::FIELD_LAST)
            written[it.field_sel][it.cell_index] = 1'b1;
        if (it.req_type == sgma_pkg::REQ_STEP && it.last_term &&
            sb.comp <= sgma_pkg::FIELD_LAST &&
            (sb.mode == sgma_pkg::MODE_FLUX || sb.mode == sgma_pkg::MODE_RESTORE))
            written[sb.comp][it.cell_index] = 1'b1;
        sent++;
    endtask

    task settle();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task set_reg(logic idx, logic [1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_reg(idx, v);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task host_request(logic [1:0] req, logic [1:0] sel, logic [11:0] cell_idx,
                      logic [63:0] data);
        sgma_pkg::t_in_item it;
        it = '0;
        it.req_type = req;
        it.field_sel = sel;
        it.cell_index = cell_idx;
        it.data_value = data;
        it.point_index = 12'($urandom);
        it.coeff = {$urandom, $urandom};
        it.has_term = 1'($urandom);
        it.last_term = 1'($urandom);
        send(it);
    endtask

    task step(logic has, logic last, logic [11:0] cell_idx, logic [11:0] point,
              logic [63:0] c, logic [63:0] d);
        sgma_pkg::t_in_item it;
        it.req_type = sgma_pkg::REQ_STEP;
        it.field_sel = 2'($urandom);
        it.cell_index = cell_idx;
        it.point_index = point;
        it.coeff = c;
        it.data_value = d;
        it.has_term = has;
        it.last_term = last;
        send(it);
    endtask

    task stencil_run(int terms);
        logic [1:0] c;
        c = sb.comp;
        for (int t = 0; t < terms; t++)
            step((sb.mode == sgma_pkg::MODE_FLUX) ? ($urandom_range(0, 5) != 0) :
                 1'($urandom),
                 1'b0, 12'($urandom), live_cell(c), rand_double(), rand_double());
        step(1'($urandom), 1'b1,
             (sb.mode == sgma_pkg::MODE_SAVE) ? live_cell(c) : 12'($urandom),
             live_cell(c), rand_double(), rand_double());
    endtask

    task random_request();
        int k;
        logic [1:0] sel;
        k = $urandom_range(0, 99);
        sel = ($urandom_range(0, 9) == 0) ? FIELD_BAD : 2'($urandom_range(0, 2));
        if (k < 15)
            host_request(sgma_pkg::REQ_WRITE, sel, 12'($urandom), rand_double());
        else if (k < 32)
            host_request(sgma_pkg::REQ_READ, sel, live_cell(sel), 64'd0);
        else if (k < 35)
            host_request(REQ_BAD, sel, 12'($urandom), rand_double());
        else
            stencil_run($urandom_range(0, 4));
    endtask

    initial begin
        int ph;
        logic [1:0] m;
        logic [1:0] c;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int f = 0; f <= sgma_pkg::FIELD_LAST; f++)
            for (int i = 0; i < 64; i++) begin
                host_request(sgma_pkg::REQ_WRITE, 2'(f), 12'(i), rand_double());
                host_request(sgma_pkg::REQ_WRITE, 2'(f), 12'(4032 + i), rand_double());
            end

        // directed: field extremes, bad codes, empty stencil, every mode
        host_request(sgma_pkg::REQ_WRITE, 2'd0, 12'd4095, 64'hFFFF_FFFF_FFFF_FFFF);
        host_request(sgma_pkg::REQ_READ, 2'd0, 12'd4095, 64'd0);
        host_request(sgma_pkg::REQ_WRITE, 2'd2, 12'd0, 64'd0);
        host_request(sgma_pkg::REQ_READ, 2'd2, 12'd0, 64'd0);
        host_request(sgma_pkg::REQ_WRITE, FIELD_BAD, 12'd5, 64'h3FF0_0000_0000_0000);
        host_request(sgma_pkg::REQ_READ, FIELD_BAD, 12'd4095, 64'd0);
        host_request(REQ_BAD, 2'd1, 12'd7, 64'h4000_0000_0000_0000);
        step(1'b1, 1'b0, 12'd1, 12'd4095, 64'h3FF0_0000_0000_0000, 64'd0);
        step(1'b1, 1'b0, 12'd1, 12'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
        step(1'b0, 1'b1, 12'd4095, 12'd2, 64'd0, 64'h3FF0_0000_0000_0000);
        step(1'b0, 1'b1, 12'd3, 12'd2, 64'd0, 64'hC000_0000_0000_0000);
        host_request(sgma_pkg::REQ_READ, 2'd0, 12'd3, 64'd0);
        step(1'b1, 1'b0, 12'd0, 12'd9, 64'h4008_0000_0000_0000, 64'd0);
        settle();
        set_reg(sgma_pkg::CFG_MODE, sgma_pkg::MODE_SAVE);
        step(1'b1, 1'b0, 12'd3, 12'd9, 64'd0, 64'd0);
        step(1'b1, 1'b1, 12'd3, 12'd9, 64'd0, 64'd0);
        settle();
        set_reg(sgma_pkg::CFG_MODE, sgma_pkg::MODE_RESTORE);
        set_reg(sgma_pkg::CFG_COMPONENT, 2'd2);
        step(1'b1, 1'b0, 12'd4095, 12'd0, 64'd0, 64'h1234_5678_9ABC_DEF0);
        step(1'b0, 1'b1, 12'd4095, 12'd0, 64'd0, 64'h1234_5678_9ABC_DEF0);
        host_request(sgma_pkg::REQ_READ, 2'd2, 12'd4095, 64'd0);
        settle();
        set_reg(sgma_pkg::CFG_MODE, MODE_BAD);
        step(1'b1, 1'b1, 12'd10, 12'd10, 64'h3FF0_0000_0000_0000, 64'd0);
        settle();
        set_reg(sgma_pkg::CFG_MODE, sgma_pkg::MODE_FLUX);
        set_reg(sgma_pkg::CFG_COMPONENT, 2'd3);
        step(1'b1, 1'b0, 12'd10, 12'd4095, 64'h3FF0_0000_0000_0000, 64'd0);
        step(1'b1, 1'b1, 12'd10, 12'd0, 64'h3FF0_0000_0000_0000,
             64'h3FF0_0000_0000_0000);
        settle();
        set_reg(sgma_pkg::CFG_MODE, sgma_pkg::MODE_SAVE);
        step(1'b0, 1'b1, 12'd20, 12'd0, 64'd0, 64'd0);
        settle();

        sent = 0;
        ph = 0;
        while (sent < RANDOM_REQUESTS) begin
            m = ($urandom_range(0, 9) == 0) ? MODE_BAD : 2'($urandom_range(0, 2));
            c = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            if (ph < 3) begin
                m = 2'(ph);
                c = 2'(ph);
            end
            set_reg(sgma_pkg::CFG_MODE, m);
            set_reg(sgma_pkg::CFG_COMPONENT, c);
            no_gaps = ($urandom_range(0, 3) == 0);
            if (ph == 4) begin
                no_gaps = 1'b1;
                hold_req = 1'b1;
            end
            repeat ($urandom_range(15, 40)) random_request();
            settle();
            ph++;
        end

        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (sb.fails == 0 && sb.pending.size() == 0)
            $display("[stencil_gather_mac_apply_core] OK");
        else
            $display("[stencil_gather_mac_apply_core] ERROR");
        $finish;
    end
endmodule

`default_nettype wire
